@@ hdl/lpg_pkg.sv @@
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared constants, operation codes and color type for the line pixel
// generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int FIELD_BITS         = 16;
   localparam int COLOR_BITS         = 8;
   localparam int QUEUE_DEPTH        = 2;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] alpha;
      logic [COLOR_BITS-1:0] blue;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] red;
   } color_type;

endpackage

@@ hdl/lpg_req_if.sv @@
// ----------------------------------------------------------------------------
// lpg_req_if
// Request channel: start a line or advance to its next pixel.
// ----------------------------------------------------------------------------
interface lpg_req_if;
   import lpg_pkg::*;

   logic                         valid;
   logic                         ready;
   op_type                       operation;
   logic signed [FIELD_BITS-1:0] start_x;
   logic signed [FIELD_BITS-1:0] start_y;
   logic signed [FIELD_BITS-1:0] end_x;
   logic signed [FIELD_BITS-1:0] end_y;
   logic [COLOR_BITS-1:0]        red;
   logic [COLOR_BITS-1:0]        green;
   logic [COLOR_BITS-1:0]        blue;
   logic [COLOR_BITS-1:0]        alpha;

   modport source (
      output valid, operation, start_x, start_y, end_x, end_y,
             red, green, blue, alpha,
      input  ready
   );

   modport sink (
      input  valid, operation, start_x, start_y, end_x, end_y,
             red, green, blue, alpha,
      output ready
   );

endinterface

@@ hdl/lpg_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lpg_rsp_if
// Response channel: one rasterized pixel with its color.
// ----------------------------------------------------------------------------
interface lpg_rsp_if;
   import lpg_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [FIELD_BITS-1:0] pixel_x;
   logic signed [FIELD_BITS-1:0] pixel_y;
   logic [COLOR_BITS-1:0]        out_red;
   logic [COLOR_BITS-1:0]        out_green;
   logic [COLOR_BITS-1:0]        out_blue;
   logic [COLOR_BITS-1:0]        out_alpha;
   logic                         last_pixel;

   modport source (
      output valid, pixel_x, pixel_y, out_red, out_green, out_blue, out_alpha,
             last_pixel,
      input  ready
   );

   modport sink (
      input  valid, pixel_x, pixel_y, out_red, out_green, out_blue, out_alpha,
             last_pixel,
      output ready
   );

endinterface

@@ hdl/line_pixel_generator.sv @@
// ----------------------------------------------------------------------------
// line_pixel_generator
// Integer line rasterizer: a start request latches two endpoints and a color,
// each advance request then yields the next pixel of the line.
//
// Channels: req_ch takes requests (operation start or advance, endpoints,
// color), rsp_ch gives pixels with their color and a last-pixel flag. Both
// use valid/ready; a request moves when valid and ready are high together.
// A start request gives no response; an advance while no line is active
// gives none either. A start replaces any line still in progress.
// An advance passes the setup register and the two-entry command queue, and
// its pixel is then loaded into the output register that drives rsp_ch.
// Throughput: one request per cycle, so one pixel per cycle while advances
// stream in and the receiver holds ready high; the error update in the
// stepping unit keeps that rate. The queue lets the request side keep moving
// while a finished pixel waits in the output register.
// Reset clears the queue, the output register and the active line. When the
// receiver holds ready low, the pixel stays on rsp_ch, the queue fills and
// req_ch ready drops once the setup register is also occupied.
// ----------------------------------------------------------------------------
module line_pixel_generator #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   lpg_req_if.sink   req_ch,
   lpg_rsp_if.source rsp_ch
);
   import lpg_pkg::*;

   localparam int CW = COORD_BITS;

   typedef struct packed {
      op_type               op;
      logic                 steep;
      logic                 minor_down;
      logic signed [CW-1:0] major_pos;
      logic signed [CW-1:0] major_end;
      logic signed [CW-1:0] minor_pos;
      logic [CW:0]          major_delta;
      logic [CW:0]          minor_delta;
      logic [CW:0]          delta_diff;
      color_type            color;
   } cmd_type;

   cmd_type push_data, pop_data;
   logic    q_push, q_full, q_pop, q_empty;

   lpg_front #(
      .COORD_BITS (COORD_BITS),
      .cmd_type   (cmd_type)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (push_data)
   );

   lpg_queue #(
      .DEPTH      (QUEUE_DEPTH),
      .entry_type (cmd_type)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   lpg_back #(
      .COORD_BITS (COORD_BITS),
      .cmd_type   (cmd_type)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (pop_data),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

@@ hdl/lpg_front.sv @@
// ----------------------------------------------------------------------------
// lpg_front
// Takes requests, measures both axes in a first register stage and turns a
// start request into an ordered major/minor line setup for the queue.
// ----------------------------------------------------------------------------
module lpg_front #(
   parameter int  COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT,
   parameter type cmd_type   = logic
) (
   input  logic    clock,
   input  logic    reset,
   lpg_req_if.sink req_ch,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_data
);
   import lpg_pkg::*;

   localparam int CW = COORD_BITS;

   function automatic logic signed [CW-1:0] coord_in(input logic [FIELD_BITS-1:0] raw);
      logic [CW+FIELD_BITS-1:0] wide;
      wide = {{CW{1'b0}}, raw};
      return wide[CW-1:0];
   endfunction

   // stage a registers
   logic                 a_valid_ff, a_valid_in;
   op_type               a_op_ff;
   logic signed [CW-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [CW:0]          adx_ff, ady_ff;
   logic                 ax_lt_bx_ff, bx_lt_ax_ff, ay_lt_by_ff, by_lt_ay_ff;
   color_type            color_ff;

   logic signed [CW-1:0] ax_in, ay_in, bx_in, by_in;
   logic signed [CW:0]   dxab, dxba, dyab, dyba;
   logic [CW:0]          adx_in, ady_in;
   logic                 req_take;

   assign req_ch.ready = !a_valid_ff || !q_full;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign q_push       = a_valid_ff && !q_full;

   always_comb begin
      ax_in  = coord_in(req_ch.start_x);
      ay_in  = coord_in(req_ch.start_y);
      bx_in  = coord_in(req_ch.end_x);
      by_in  = coord_in(req_ch.end_y);
      dxab   = {ax_in[CW-1], ax_in} - {bx_in[CW-1], bx_in};
      dxba   = {bx_in[CW-1], bx_in} - {ax_in[CW-1], ax_in};
      dyab   = {ay_in[CW-1], ay_in} - {by_in[CW-1], by_in};
      dyba   = {by_in[CW-1], by_in} - {ay_in[CW-1], ay_in};
      adx_in = dxab[CW] ? dxba : dxab;
      ady_in = dyab[CW] ? dyba : dyab;
   end

   always_comb begin
      a_valid_in = (a_valid_ff && !q_push) || req_take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_op_ff     <= req_ch.operation;
         ax_ff       <= ax_in;
         ay_ff       <= ay_in;
         bx_ff       <= bx_in;
         by_ff       <= by_in;
         adx_ff      <= adx_in;
         ady_ff      <= ady_in;
         ax_lt_bx_ff <= dxab[CW];
         bx_lt_ax_ff <= dxba[CW];
         ay_lt_by_ff <= dyab[CW];
         by_lt_ay_ff <= dyba[CW];
         color_ff    <= '{alpha: req_ch.alpha, blue: req_ch.blue,
                          green: req_ch.green, red: req_ch.red};
      end
   end

   // stage b: pick major axis and order endpoints along it
   logic [CW+1:0] s_xy, s_yx;
   logic          steep, swap;

   always_comb begin
      s_xy  = {1'b0, adx_ff} - {1'b0, ady_ff};
      s_yx  = {1'b0, ady_ff} - {1'b0, adx_ff};
      steep = s_xy[CW+1];
      swap  = steep ? by_lt_ay_ff : bx_lt_ax_ff;

      q_data            = '0;
      q_data.op         = a_op_ff;
      q_data.steep      = steep;
      q_data.color      = color_ff;
      q_data.delta_diff = steep ? s_yx[CW:0] : s_xy[CW:0];
      if (steep) begin
         q_data.major_pos   = swap ? by_ff : ay_ff;
         q_data.major_end   = swap ? ay_ff : by_ff;
         q_data.minor_pos   = swap ? bx_ff : ax_ff;
         q_data.major_delta = ady_ff;
         q_data.minor_delta = adx_ff;
         q_data.minor_down  = swap ? !bx_lt_ax_ff : !ax_lt_bx_ff;
      end else begin
         q_data.major_pos   = swap ? bx_ff : ax_ff;
         q_data.major_end   = swap ? ax_ff : bx_ff;
         q_data.minor_pos   = swap ? by_ff : ay_ff;
         q_data.major_delta = adx_ff;
         q_data.minor_delta = ady_ff;
         q_data.minor_down  = swap ? !by_lt_ay_ff : !ay_lt_by_ff;
      end
   end

endmodule

@@ hdl/lpg_queue.sv @@
// ----------------------------------------------------------------------------
// lpg_queue
// Small first-in first-out command queue between the front and back parts.
// ----------------------------------------------------------------------------
module lpg_queue #(
   parameter int  DEPTH      = lpg_pkg::QUEUE_DEPTH,
   parameter type entry_type = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      empty
);
   import lpg_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   entry_type           slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/lpg_back.sv @@
// ----------------------------------------------------------------------------
// lpg_back
// Holds the active line, steps it one pixel per advance command and keeps
// the response output register.
// ----------------------------------------------------------------------------
module lpg_back #(
   parameter int  COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT,
   parameter type cmd_type   = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  cmd_type   q_data,
   output logic      q_pop,
   lpg_rsp_if.source rsp_ch
);
   import lpg_pkg::*;

   localparam int CW = COORD_BITS;

   function automatic logic signed [FIELD_BITS-1:0] coord_out(input logic signed [CW-1:0] p);
      logic [CW+FIELD_BITS-1:0] wide;
      wide = {{FIELD_BITS{p[CW-1]}}, p};
      return wide[FIELD_BITS-1:0];
   endfunction

   // line state
   logic                   active_ff, active_in;
   logic                   steep_ff, steep_in;
   logic                   down_ff, down_in;
   logic signed [CW-1:0]   major_pos_ff, major_pos_in;
   logic signed [CW-1:0]   major_end_ff, major_end_in;
   logic signed [CW-1:0]   minor_pos_ff, minor_pos_in;
   logic signed [CW+1:0]   error_ff, error_in;
   logic [CW:0]            minor_delta_ff, minor_delta_in;
   logic [CW:0]            delta_diff_ff, delta_diff_in;
   color_type              color_ff, color_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [FIELD_BITS-1:0] pixel_x_ff, pixel_x_in;
   logic signed [FIELD_BITS-1:0] pixel_y_ff, pixel_y_in;
   color_type                    out_color_ff, out_color_in;
   logic                         last_ff, last_in;

   logic                 is_last;
   logic signed [CW+1:0] err_sub, err_add;

   assign q_pop = !q_empty && (!rsp_valid_ff || rsp_ch.ready);

   assign is_last = (major_pos_ff == major_end_ff);
   // error minus minor delta, and the same with the major delta added back
   assign err_sub = error_ff - $signed({1'b0, minor_delta_ff});
   assign err_add = error_ff + $signed({1'b0, delta_diff_ff});

   always_comb begin
      active_in      = active_ff;
      steep_in       = steep_ff;
      down_in        = down_ff;
      major_pos_in   = major_pos_ff;
      major_end_in   = major_end_ff;
      minor_pos_in   = minor_pos_ff;
      error_in       = error_ff;
      minor_delta_in = minor_delta_ff;
      delta_diff_in  = delta_diff_ff;
      color_in       = color_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      pixel_x_in     = pixel_x_ff;
      pixel_y_in     = pixel_y_ff;
      out_color_in   = out_color_ff;
      last_in        = last_ff;

      if (q_pop) begin
         unique case (q_data.op)
            OP_START: begin
               active_in      = 1'b1;
               steep_in       = q_data.steep;
               down_in        = q_data.minor_down;
               major_pos_in   = q_data.major_pos;
               major_end_in   = q_data.major_end;
               minor_pos_in   = q_data.minor_pos;
               error_in       = $signed({2'b00, q_data.major_delta[CW:1]});
               minor_delta_in = q_data.minor_delta;
               delta_diff_in  = q_data.delta_diff;
               color_in       = q_data.color;
            end
            OP_ADVANCE: begin
               // advance with no active line is dropped
               if (active_ff) begin
                  rsp_valid_in = 1'b1;
                  pixel_x_in   = coord_out(steep_ff ? minor_pos_ff : major_pos_ff);
                  pixel_y_in   = coord_out(steep_ff ? major_pos_ff : minor_pos_ff);
                  out_color_in = color_ff;
                  last_in      = is_last;
                  if (err_sub[CW+1]) begin
                     error_in     = err_add;
                     minor_pos_in = down_ff ? minor_pos_ff - 1'b1 : minor_pos_ff + 1'b1;
                  end else begin
                     error_in = err_sub;
                  end
                  if (is_last) begin
                     active_in = 1'b0;
                  end else begin
                     major_pos_in = major_pos_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steep_ff       <= steep_in;
      down_ff        <= down_in;
      major_pos_ff   <= major_pos_in;
      major_end_ff   <= major_end_in;
      minor_pos_ff   <= minor_pos_in;
      error_ff       <= error_in;
      minor_delta_ff <= minor_delta_in;
      delta_diff_ff  <= delta_diff_in;
      color_ff       <= color_in;
      pixel_x_ff     <= pixel_x_in;
      pixel_y_ff     <= pixel_y_in;
      out_color_ff   <= out_color_in;
      last_ff        <= last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pixel_x    = pixel_x_ff;
   assign rsp_ch.pixel_y    = pixel_y_ff;
   assign rsp_ch.out_red    = out_color_ff.red;
   assign rsp_ch.out_green  = out_color_ff.green;
   assign rsp_ch.out_blue   = out_color_ff.blue;
   assign rsp_ch.out_alpha  = out_color_ff.alpha;
   assign rsp_ch.last_pixel = last_ff;

endmodule

@@ test/line_pixel_generator_tb.sv @@
// ----------------------------------------------------------------------------
// line_pixel_generator_tb
// Self-checking bench for the line rasterizer. Start and advance requests are
// queued up front and sent in random bursts. Each accepted request goes
// through a cycle-free line stepper that predicts the pixels. Returned pixels
// are compared field by field in order while the pixel sink stalls at random,
// including two long hold-offs and at least one full drain before a new line.
// ----------------------------------------------------------------------------
module line_pixel_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lpg_pkg::*;

   localparam int CW              = FIELD_BITS;
   localparam int RESET_CYCLES    = 7;
   localparam int DRAIN_CYCLES    = 10;
   localparam int REPORT_LIMIT    = 10;
   localparam int LINE_ITEMS      = 1250;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int HOLD_OFF_EVERY  = 450;
   localparam int HOLD_OFF_COUNT  = 2;
   localparam int MAX_SHORT_SPAN  = 12;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      op_type    op;
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
      color_type color;
      logic      hold_until_drained;
   } line_req_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      color_type color;
      logic      last;
   } pixel_type;

   typedef enum {SINK_FREE, SINK_MOSTLY, SINK_SPARSE, SINK_TOGGLE} sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5ns clock = ~clock;

   lpg_req_if req_ch();
   lpg_rsp_if rsp_ch();

   line_pixel_generator i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // request being offered and pixel sink ready
   line_req_type offer       = '0;
   logic         offer_valid = 1'b0;
   logic         offer_taken = 1'b0;
   logic         sink_ready  = 1'b0;

   assign req_ch.valid     = offer_valid;
   assign req_ch.operation = offer.op;
   assign req_ch.start_x   = offer.sx;
   assign req_ch.start_y   = offer.sy;
   assign req_ch.end_x     = offer.ex;
   assign req_ch.end_y     = offer.ey;
   assign req_ch.red       = offer.color.red;
   assign req_ch.green     = offer.color.green;
   assign req_ch.blue      = offer.color.blue;
   assign req_ch.alpha     = offer.color.alpha;
   assign rsp_ch.ready     = sink_ready;

   line_req_type line_reqs[$];
   pixel_type    pixels_due[$];

   // line stepper state
   logic                 line_on    = 1'b0;
   logic                 steep      = 1'b0;
   coord_type            major_at   = '0;
   coord_type            major_stop = '0;
   coord_type            minor_at   = '0;
   logic signed [CW+1:0] err        = '0;
   logic [CW:0]          major_span = '0;
   logic [CW:0]          minor_span = '0;
   logic                 minor_dec  = 1'b0;
   color_type            line_rgba  = '0;

   int            errors      = 0;
   int            req_count   = 0;
   int            starts_seen = 0;
   int            pixels_seen = 0;
   int            lines_done  = 0;
   int            drain_pauses = 0;
   int            gen_items   = 0;
   int            gen_left    = 0;
   int            burst_left  = 0;
   int            gap_left    = 0;
   int unsigned   mode_left   = 0;
   int unsigned   hold_off_left = 0;
   int            hold_offs   = 0;
   sink_mode_type sink_mode   = SINK_FREE;

   function automatic int span(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   task automatic rasterize(input line_req_type r);
      int        ax, ay, bx, by, swap;
      pixel_type px;
      if (r.op == OP_START) begin
         ax = r.sx;
         ay = r.sy;
         bx = r.ex;
         by = r.ey;
         // a tie between the spans counts as shallow
         steep = span(ax, bx) < span(ay, by);
         if (steep) begin
            swap = ax; ax = ay; ay = swap;
            swap = bx; bx = by; by = swap;
         end
         if (ax > bx) begin
            swap = ax; ax = bx; bx = swap;
            swap = ay; ay = by; by = swap;
         end
         major_at   = coord_type'(ax);
         major_stop = coord_type'(bx);
         minor_at   = coord_type'(ay);
         major_span = (CW+1)'(bx - ax);
         minor_span = (CW+1)'(span(ay, by));
         err        = (CW+2)'((bx - ax) / 2);
         minor_dec  = !(ay < by);
         line_rgba  = r.color;
         line_on    = 1'b1;
         starts_seen++;
      end else if (line_on) begin
         px.x     = steep ? minor_at : major_at;
         px.y     = steep ? major_at : minor_at;
         px.color = line_rgba;
         px.last  = (major_at == major_stop);
         pixels_due.push_back(px);
         err = err - $signed({1'b0, minor_span});
         if (err < 0) begin
            minor_at = minor_dec ? minor_at - coord_type'(1) : minor_at + coord_type'(1);
            err = err + $signed({1'b0, major_span});
         end
         if (px.last) line_on = 1'b0;
         else major_at = major_at + coord_type'(1);
      end
   endtask

   task automatic check_pixel();
      pixel_type got, want;
      got.x           = rsp_ch.pixel_x;
      got.y           = rsp_ch.pixel_y;
      got.color.red   = rsp_ch.out_red;
      got.color.green = rsp_ch.out_green;
      got.color.blue  = rsp_ch.out_blue;
      got.color.alpha = rsp_ch.out_alpha;
      got.last        = rsp_ch.last_pixel;
      if (pixels_due.size() == 0) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b",
                     $time, got.x, got.y, got.color, got.last);
      end else begin
         want = pixels_due.pop_front();
         pixels_seen++;
         if (want.last) lines_done++;
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("%0t: pixel mismatch, expected x=%0d y=%0d color=%h last=%b",
                        $time, want.x, want.y, want.color, want.last);
               $display("%0t:                 actual   x=%0d y=%0d color=%h last=%b",
                        $time, got.x, got.y, got.color, got.last);
            end
         end
      end
   endtask

   always @(posedge clock) begin : check_and_predict
      if (reset) begin
         offer_taken <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_pixel();
         if (req_ch.valid && req_ch.ready) begin
            rasterize(offer);
            req_count++;
         end
         offer_taken <= req_ch.valid && req_ch.ready;
      end
   end

   // request driver: bursts of random length with random gaps
   always @(negedge clock) begin : req_driver
      if (reset) begin
         offer_valid <= 1'b0;
      end else if (!offer_valid || offer_taken) begin
         if (gap_left > 0) begin
            gap_left    <= gap_left - 1;
            offer_valid <= 1'b0;
         end else if (line_reqs.size() == 0 ||
                      (line_reqs[0].hold_until_drained && pixels_due.size() != 0)) begin
            offer_valid <= 1'b0;
         end else begin
            if (line_reqs[0].hold_until_drained) drain_pauses++;
            offer       <= line_reqs.pop_front();
            offer_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   always @(negedge clock) begin : rsp_stall_pattern
      logic go;
      case (sink_mode)
         SINK_FREE:   go = 1'b1;
         SINK_MOSTLY: go = ($urandom_range(0, 3) != 0);
         SINK_SPARSE: go = ($urandom_range(0, 3) == 0);
         default:     go = mode_left[0];
      endcase
      sink_ready <= go && (hold_off_left == 0);
      if (mode_left == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
         mode_left <= $urandom_range(8, 80);
      end else begin
         mode_left <= mode_left - 1;
      end
   end

   // long sink hold-off so the request side backs up
   always @(negedge clock) begin : rsp_hold_off
      if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
      end else if (hold_offs < HOLD_OFF_COUNT &&
                   req_count >= (hold_offs + 1) * HOLD_OFF_EVERY) begin
         hold_off_left <= HOLD_OFF_CYCLES;
         hold_offs     <= hold_offs + 1;
      end
   end

   function automatic line_req_type noise_req(op_type op);
      line_req_type r;
      r.op                 = op;
      r.sx                 = coord_type'($urandom);
      r.sy                 = coord_type'($urandom);
      r.ex                 = coord_type'($urandom);
      r.ey                 = coord_type'($urandom);
      r.color              = color_type'($urandom);
      r.hold_until_drained = 1'b0;
      return r;
   endfunction

   task automatic add_advances(int n);
      repeat (n) begin
         line_reqs.push_back(noise_req(OP_ADVANCE));
         if (gen_left > 0) begin
            gen_left--;
            gen_items++;
         end
      end
   endtask

   task automatic add_line(int sx, int sy, int ex, int ey, color_type rgba, int n,
                           bit hold);
      line_req_type r;
      r                    = noise_req(OP_START);
      r.sx                 = coord_type'(sx);
      r.sy                 = coord_type'(sy);
      r.ex                 = coord_type'(ex);
      r.ey                 = coord_type'(ey);
      r.color              = rgba;
      r.hold_until_drained = hold;
      line_reqs.push_back(r);
      gen_items++;
      gen_left = ((span(sx, ex) > span(sy, ey)) ? span(sx, ex) : span(sy, ey)) + 1;
      add_advances(n);
   endtask

   // end point a short step away, folded back inside the coordinate range
   function automatic int near_point(int from, int step);
      int to;
      to = from + step;
      if (to > 32767 || to < -32768) to = from - step;
      return to;
   endfunction

   initial begin : stimulus
      int sx, sy, ex, ey, len, n, pick;

      // advance with no line, single-point line, full-range lines replaced
      // midway, steep line, diagonal tie, reversed flat line after a drain
      add_advances(1);
      add_line(0, 0, 0, 0, '0, 1, 0);
      add_line(-32768, -32768, 32767, 32767, '1, 2, 0);
      add_line(32767, -32768, -32768, 32000, color_type'($urandom), 2, 0);
      add_line(1, 0, -1, 5, color_type'($urandom), 6, 0);
      add_line(0, 0, 2, -2, color_type'($urandom), 3, 0);
      add_line(2, 7, -1, 7, color_type'($urandom), 4, 1);

      while (gen_items < LINE_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            add_advances($urandom_range(1, 3));
         end else if (pick == 1) begin
            add_line(int'(coord_type'($urandom)), int'(coord_type'($urandom)),
                     int'(coord_type'($urandom)), int'(coord_type'($urandom)),
                     color_type'($urandom), $urandom_range(0, 4), 0);
         end else begin
            sx  = int'(coord_type'($urandom));
            sy  = int'(coord_type'($urandom));
            ex  = near_point(sx, int'($urandom_range(0, 2 * MAX_SHORT_SPAN)) - MAX_SHORT_SPAN);
            ey  = near_point(sy, int'($urandom_range(0, 2 * MAX_SHORT_SPAN)) - MAX_SHORT_SPAN);
            len = ((span(sx, ex) > span(sy, ey)) ? span(sx, ex) : span(sy, ey)) + 1;
            case ($urandom_range(0, 9))
               0:       n = $urandom_range(0, len - 1);
               1:       n = len + $urandom_range(1, 2);
               default: n = len;
            endcase
            add_line(sx, sy, ex, ey, color_type'($urandom), n, $urandom_range(0, 99) == 0);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (line_reqs.size() != 0 || offer_valid) @(posedge clock);
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d line starts, %0d pixels checked, %0d lines finished",
               req_count, starts_seen, pixels_seen, lines_done);
      $display("sender waited for a full drain %0d times, sink held off %0d times, %0d errors",
               drain_pauses, hold_offs, errors);
      if (errors == 0) begin
         $display("line_pixel_generator_tb: PASS");
      end else begin
         $display("line_pixel_generator_tb: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #2ms;
      $display("timeout: %0d pixels still expected", pixels_due.size());
      $display("line_pixel_generator_tb: FAIL");
      $finish;
   end

endmodule
